// ===== sv/sha_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and round functions for the SHA-256 digest block.
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_OUT
  } core_state_e;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] InitVec [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

// ===== sv/sha256_message_digest.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 message digest
// Hashes a byte stream and returns the eight digest words per message.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel, one byte or end mark each, into a
// four-entry queue. The core packs bytes into 64-byte blocks; the 64th byte
// starts a compression of 64 rounds, one per cycle, followed by a fold into
// the hash value. An end mark pads the block and runs one or two more
// compressions, then the eight digest words leave on m_axis, word 0 first,
// tlast on word 7. While m_axis is stalled the current word is held and no
// further requests are taken from the queue. Reset loads the initial hash
// value, clears the byte count and empties the queue.
// ----------------------------------------------------------------------------
module sha256_message_digest (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte
  input  wire logic        s_axis_tuser,   // byte_present
  input  wire logic        s_axis_tlast,   // end_of_message
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // digest_word
  output logic [2:0]       m_axis_tuser,   // word_index
  output logic             m_axis_tlast    // last_word
);
  import sha_pkg::*;

  req_t in_req, q_req;
  logic q_valid, q_ready;

  assign in_req = '{data_byte: s_axis_tdata, byte_present: s_axis_tuser,
                    end_of_message: s_axis_tlast};

  sha_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(s_axis_tvalid), .wr_ready_o(s_axis_tready), .wr_data_i(in_req),
    .rd_valid_o(q_valid), .rd_ready_i(q_ready), .rd_data_o(q_req)
  );

  sha_core u_core (
    .clk_i, .rst_ni,
    .req_valid_i(q_valid), .req_ready_o(q_ready), .req_i(q_req),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .digest_word_o(m_axis_tdata), .word_index_o(m_axis_tuser),
    .last_word_o(m_axis_tlast)
  );
endmodule
`default_nettype wire

// ===== sv/sha_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 request queue
// Short queue that decouples the input channel from the compression core.
// ----------------------------------------------------------------------------
module sha_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_valid_i,
  output logic               wr_ready_o,
  input  wire sha_pkg::req_t wr_data_i,
  output logic               rd_valid_o,
  input  wire logic          rd_ready_i,
  output sha_pkg::req_t      rd_data_o
);
  import sha_pkg::*;

  req_t       mem_q [4];
  logic [1:0] wptr_q, rptr_q;
  logic [2:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 3'd4);
  assign rd_valid_o = (cnt_q != 3'd0);
  assign rd_data_o  = mem_q[rptr_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr) wptr_q <= wptr_q + 2'd1;
      if (rd) rptr_q <= rptr_q + 2'd1;
      cnt_q <= cnt_q + {2'b0, wr} - {2'b0, rd};
    end
  end
endmodule
`default_nettype wire

// ===== sv/sha_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 core
// Packs bytes, pads, runs one compression round per cycle and emits the digest.
// ----------------------------------------------------------------------------
module sha_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output logic               req_ready_o,
  input  wire sha_pkg::req_t req_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [31:0]        digest_word_o,
  output logic [2:0]         word_index_o,
  output logic               last_word_o
);
  import sha_pkg::*;

  core_state_e st_q, st_d;
  logic [31:0] blk_q [16];
  logic [31:0] hv_q [8];
  logic [31:0] r_q [8];
  logic [31:0] w_q [16];
  logic [63:0] cnt_q;
  logic [5:0]  rnd_q;
  logic [2:0]  oidx_q;
  logic        fin_q;   // A message end is pending after the current block.
  logic        pad2_q;  // The length-only block is still to be compressed.
  logic        padded_q;  // Padding of the final block has begun.

  logic [5:0]  pos;
  logic [3:0]  wi;
  logic [4:0]  sh;
  logic [31:0] wnew, wt, s1, ch, t1, s0, mj, t2, g0, g1;
  logic        take, start;

  assign pos = cnt_q[5:0];
  assign wi  = pos[5:2];
  assign sh  = {~pos[1:0], 3'b000};

  assign g0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
  assign g1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
  assign wnew = w_q[0] + g0 + w_q[9] + g1;
  assign wt = (rnd_q < 6'd16) ? w_q[0] : wnew;
  assign s1 = rotr(r_q[4], 6) ^ rotr(r_q[4], 11) ^ rotr(r_q[4], 25);
  assign ch = (r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6]);
  assign t1 = r_q[7] + s1 + ch + RoundK[rnd_q] + wt;
  assign s0 = rotr(r_q[0], 2) ^ rotr(r_q[0], 13) ^ rotr(r_q[0], 22);
  assign mj = (r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]);
  assign t2 = s0 + mj;

  assign req_ready_o   = (st_q == ST_IDLE);
  assign take          = req_valid_i && req_ready_o;
  assign out_valid_o   = (st_q == ST_OUT);
  assign digest_word_o = hv_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 3'd7);

  always_comb begin
    st_d  = st_q;
    start = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (take) begin
          if (req_i.byte_present && pos == 6'd63) begin
            st_d = ST_ROUND;
            start = 1'b1;
          end else if (req_i.end_of_message) begin
            st_d = ST_PAD;
          end
        end
      end
      ST_ROUND: if (rnd_q == 6'd63) st_d = ST_FOLD;
      ST_FOLD: begin
        if (pad2_q) begin
          st_d = ST_PAD;
        end else if (fin_q && !padded_q) begin
          st_d = ST_PAD;
        end else if (fin_q) begin
          st_d = ST_OUT;
        end else begin
          st_d = ST_IDLE;
        end
      end
      ST_PAD: st_d = ST_ROUND;
      ST_OUT: if (out_ready_i && oidx_q == 3'd7) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      cnt_q    <= '0;
      fin_q    <= 1'b0;
      pad2_q   <= 1'b0;
      padded_q <= 1'b0;
      oidx_q   <= '0;
      rnd_q    <= '0;
      for (int i = 0; i < 8; i++) hv_q[i] <= InitVec[i];
    end else begin
      st_q <= st_d;
      case (st_q)
        ST_IDLE: begin
          rnd_q <= '0;
          if (take) begin
            if (req_i.byte_present) cnt_q <= cnt_q + 64'd1;
            fin_q <= req_i.end_of_message;
          end
        end
        ST_ROUND: rnd_q <= rnd_q + 6'd1;
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) hv_q[i] <= hv_q[i] + r_q[i];
        end
        ST_PAD: begin
          rnd_q <= '0;
          padded_q <= 1'b1;
          if (pad2_q) begin
            pad2_q <= 1'b0;
          end else begin
            pad2_q <= (pos >= 6'd56);
          end
        end
        ST_OUT: begin
          if (out_ready_i) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == 3'd7) begin
              for (int i = 0; i < 8; i++) hv_q[i] <= InitVec[i];
              cnt_q <= '0;
              fin_q <= 1'b0;
              padded_q <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Block buffer, schedule and working registers.
  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && take && req_i.byte_present) begin
      if (pos[1:0] == 2'd0) begin
        blk_q[wi] <= {24'd0, req_i.data_byte} << sh;
      end else begin
        blk_q[wi] <= blk_q[wi] | ({24'd0, req_i.data_byte} << sh);
      end
    end
    if (st_q == ST_PAD) begin
      if (pad2_q) begin
        for (int i = 0; i < 14; i++) w_q[i] <= '0;
      end else begin
        for (int i = 0; i < 16; i++) begin
          if (i == int'(wi)) begin
            w_q[i] <= ((pos[1:0] == 2'd0) ? 32'd0 : blk_q[i]) |
                      ({24'd0, PadByte} << sh);
          end else if (i < int'(wi)) begin
            w_q[i] <= blk_q[i];
          end else begin
            w_q[i] <= '0;
          end
        end
      end
      if (pad2_q || pos < 6'd56) begin
        w_q[14] <= {cnt_q[60:29]};
        w_q[15] <= {cnt_q[28:0], 3'b000};
      end
      for (int i = 0; i < 8; i++) r_q[i] <= hv_q[i];
    end else if (start) begin
      for (int i = 0; i < 15; i++) w_q[i] <= blk_q[i];
      w_q[15] <= blk_q[15] | {24'd0, req_i.data_byte};
      for (int i = 0; i < 8; i++) r_q[i] <= hv_q[i];
    end else if (st_q == ST_ROUND) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
      w_q[15] <= wt;
      r_q[7] <= r_q[6];
      r_q[6] <= r_q[5];
      r_q[5] <= r_q[4];
      r_q[4] <= r_q[3] + t1;
      r_q[3] <= r_q[2];
      r_q[2] <= r_q[1];
      r_q[1] <= r_q[0];
      r_q[0] <= t1 + t2;
    end
  end
endmodule
`default_nettype wire
